FILE: hdl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
`timescale 1ns / 1ps

package isl_pkg;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 3'd0,
    CMD_PREPEND      = 3'd1,
    CMD_INSERT_AT    = 3'd2,
    CMD_REMOVE_AT    = 3'd3,
    CMD_REMOVE_FRONT = 3'd4,
    CMD_CONTAINS     = 3'd5,
    CMD_CLEAR        = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic ins;
    logic rem;
    logic srch;
  } cell_ctl_t;

endpackage

FILE: hdl/isl_cell.sv
// One storage cell of the list row: holds an entry and its search match.
`timescale 1ns / 1ps

module isl_cell #(
  parameter int IDX = 0,
  parameter int MW  = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  isl_pkg::cell_ctl_t                ctl,
  input  logic [MW-1:0]                     gap_pos,
  input  logic [MW-1:0]                     occ,
  input  logic signed [isl_pkg::VAL_W-1:0]  value,
  input  logic signed [isl_pkg::VAL_W-1:0]  left_entry,
  input  logic signed [isl_pkg::VAL_W-1:0]  right_entry,
  output logic signed [isl_pkg::VAL_W-1:0]  entry,
  output logic                              match
);

  localparam logic [MW-1:0] MY_IDX = MW'(IDX);

  logic signed [isl_pkg::VAL_W-1:0] entry_r, entry_nxt;
  logic                             match_r, match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      // Cells above the gap take their lower neighbour's entry.
      if (MY_IDX > gap_pos) begin
        entry_nxt = left_entry;
      end else if (MY_IDX == gap_pos) begin
        entry_nxt = value;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= gap_pos) begin
        entry_nxt = right_entry;
      end
    end
    match_nxt = ctl.srch && (MY_IDX < occ) && (entry_r == value);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

FILE: hdl/indexed_shift_list.sv
// Top level of the indexed shift list: command decode, occupancy and the cell row.
//
//   Channel   Ports                                   Handshake
//   command   in_command, in_value, in_position       start / busy
//   result    out_found, out_is_empty,                out_valid strobe
//             out_entry_count, out_status
//   config    cfg_wdata                               cfg_we
//
// One command is accepted per cycle while busy is low; its result appears in the cycle
// after acceptance. The cell row updates every entry in parallel at the accepting edge,
// and found is the OR-reduction of the registered per-cell match bits.
// Reset is synchronous; busy stays high while rst_n is low and the list is empty after it.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module indexed_shift_list #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [isl_pkg::CMD_W-1:0]         in_command,
  input  logic signed [isl_pkg::VAL_W-1:0]  in_value,
  input  logic [isl_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic                              out_found,
  output logic                              out_is_empty,
  output logic [isl_pkg::CNT_W-1:0]         out_entry_count,
  output logic [isl_pkg::STAT_W-1:0]        out_status,
  input  logic                              cfg_we,
  input  logic [isl_pkg::CAP_W-1:0]         cfg_wdata
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;
  localparam logic [MW-1:0] MAX_X = MW'(MAX_ENTRIES);

  logic [CW-1:0]              occ_r, occ_nxt;
  logic [isl_pkg::CAP_W-1:0]  cap_r;
  logic                       busy_r;
  logic                       out_valid_r;
  isl_pkg::status_t           stat_r, stat_nxt;

  logic                       accept;
  logic                       full;
  logic [MW-1:0]              occ_x, cap_x, pos_x, gap_pos;
  logic                       do_ins, do_rem, do_srch;
  isl_pkg::cell_ctl_t         ctl;
  isl_pkg::cmd_t              cmd;

  logic signed [isl_pkg::VAL_W-1:0] cell_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]           cell_match;

  assign accept = start && !busy_r;
  assign cmd    = isl_pkg::cmd_t'(in_command);
  assign occ_x  = MW'(occ_r);
  assign cap_x  = MW'(cap_r);
  assign pos_x  = MW'(in_position);
  assign full   = (occ_x >= cap_x) || (occ_x >= MAX_X);

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_srch  = 1'b0;
    gap_pos  = pos_x;
    occ_nxt  = occ_r;
    stat_nxt = isl_pkg::ST_OK;
    case (cmd)
      isl_pkg::CMD_APPEND: begin
        if (full) begin
          stat_nxt = isl_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          gap_pos = occ_x;
          occ_nxt = occ_r + CW'(1);
        end
      end
      isl_pkg::CMD_PREPEND: begin
        if (full) begin
          stat_nxt = isl_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          gap_pos = '0;
          occ_nxt = occ_r + CW'(1);
        end
      end
      isl_pkg::CMD_INSERT_AT: begin
        if (full) begin
          stat_nxt = isl_pkg::ST_FULL;
        end else if (pos_x > occ_x) begin
          stat_nxt = isl_pkg::ST_BAD_POS;
        end else begin
          do_ins  = 1'b1;
          occ_nxt = occ_r + CW'(1);
        end
      end
      isl_pkg::CMD_REMOVE_AT: begin
        if (occ_r == '0) begin
          stat_nxt = isl_pkg::ST_EMPTY;
        end else if (pos_x >= occ_x) begin
          stat_nxt = isl_pkg::ST_BAD_POS;
        end else begin
          do_rem  = 1'b1;
          occ_nxt = occ_r - CW'(1);
        end
      end
      isl_pkg::CMD_REMOVE_FRONT: begin
        if (occ_r == '0) begin
          stat_nxt = isl_pkg::ST_EMPTY;
        end else begin
          do_rem  = 1'b1;
          gap_pos = '0;
          occ_nxt = occ_r - CW'(1);
        end
      end
      isl_pkg::CMD_CONTAINS: begin
        do_srch = 1'b1;
      end
      isl_pkg::CMD_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctl.ins  = accept && do_ins;
  assign ctl.rem  = accept && do_rem;
  assign ctl.srch = accept && do_srch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= isl_pkg::CAP_RESET;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      stat_r      <= isl_pkg::ST_OK;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        occ_r  <= occ_nxt;
        stat_r <= stat_nxt;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic signed [isl_pkg::VAL_W-1:0] left_e, right_e;
      if (gi == 0) begin : g_first
        assign left_e = in_value;
      end else begin : g_mid_l
        assign left_e = cell_entry[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_last
        assign right_e = cell_entry[gi];
      end else begin : g_mid_r
        assign right_e = cell_entry[gi+1];
      end
      isl_cell #(
        .IDX (gi),
        .MW  (MW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .gap_pos     (gap_pos),
        .occ         (occ_x),
        .value       (in_value),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry       (cell_entry[gi]),
        .match       (cell_match[gi])
      );
    end
  endgenerate

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_found       = |cell_match;
  assign out_is_empty    = (occ_r == '0);
  assign out_entry_count = isl_pkg::CNT_W'(occ_r);
  assign out_status      = stat_r;

endmodule

FILE: hdl/isl_checker.sv
// Port-level checks on the indexed shift list, bound to the top level.
`timescale 1ns / 1ps

module isl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_found,
  input logic                       out_is_empty,
  input logic [isl_pkg::CNT_W-1:0]  out_entry_count,
  input logic [isl_pkg::STAT_W-1:0] out_status
);

  // Every accepted request gives a result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && rst_n) |=> out_valid)
    else $error("accepted request gave no result");

  // No result without a request accepted the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) && !$past(busy)))
    else $error("result without accepted request");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A hit needs an OK status and a stored entry, and an empty status needs an empty list.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == isl_pkg::ST_OK && !out_is_empty))
    else $error("found on a failed command or an empty list");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == isl_pkg::ST_EMPTY) |-> out_is_empty)
    else $error("empty status with entries held");

endmodule

bind indexed_shift_list isl_checker u_isl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_found       (out_found),
  .out_is_empty    (out_is_empty),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);
